/* hdl/msprfd_pkg.sv */
// ----------------------------------------------------------------------------
// MSP response frame decoder package
// Header bytes, command codes, event kinds and the field layout tables.
// ----------------------------------------------------------------------------
package msprfd_pkg;

  localparam int BUF_BYTES_DEF = 64;

  localparam logic [7:0] HDR_START = 8'h24;
  localparam logic [7:0] HDR_M     = 8'h4D;
  localparam logic [7:0] HDR_DIR   = 8'h3E;

  localparam logic [7:0] CMD_100 = 8'd100;
  localparam logic [7:0] CMD_101 = 8'd101;
  localparam logic [7:0] CMD_102 = 8'd102;
  localparam logic [7:0] CMD_106 = 8'd106;
  localparam logic [7:0] CMD_108 = 8'd108;
  localparam logic [7:0] CMD_109 = 8'd109;
  localparam logic [7:0] CMD_110 = 8'd110;

  localparam logic [1:0] EV_FIELD   = 2'd0;
  localparam logic [1:0] EV_REQUEST = 2'd1;
  localparam logic [1:0] EV_UNSUP   = 2'd2;

  typedef struct packed {
    logic [4:0] off;
    logic [2:0] size;
  } field_desc_t;

  function automatic logic [3:0] layout_count(input logic [7:0] code);
    logic [3:0] n;
    case (code)
      CMD_100: n = 4'd4;
      CMD_101: n = 4'd5;
      CMD_102: n = 4'd9;
      CMD_106: n = 4'd6;
      CMD_108: n = 4'd3;
      CMD_109: n = 4'd2;
      CMD_110: n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic field_desc_t fd(input int o, input int s);
    field_desc_t d;
    d.off  = 5'(o);
    d.size = 3'(s);
    return d;
  endfunction

  function automatic field_desc_t layout_field(input logic [7:0] code,
                                               input logic [3:0] idx);
    field_desc_t d;
    d = fd(0, 1);
    case (code)
      CMD_100: begin
        case (idx)
          4'd0:    d = fd(0, 1);
          4'd1:    d = fd(1, 1);
          4'd2:    d = fd(2, 1);
          default: d = fd(3, 4);
        endcase
      end
      CMD_101: begin
        case (idx)
          4'd0:    d = fd(0, 2);
          4'd1:    d = fd(2, 2);
          4'd2:    d = fd(4, 2);
          4'd3:    d = fd(6, 4);
          default: d = fd(10, 1);
        endcase
      end
      CMD_102: begin
        d.off  = {idx, 1'b0};
        d.size = 3'd2;
      end
      CMD_106: begin
        case (idx)
          4'd0:    d = fd(0, 1);
          4'd1:    d = fd(1, 1);
          4'd2:    d = fd(2, 4);
          4'd3:    d = fd(6, 4);
          4'd4:    d = fd(10, 2);
          default: d = fd(12, 2);
        endcase
      end
      CMD_108: begin
        case (idx)
          4'd0:    d = fd(0, 2);
          4'd1:    d = fd(2, 2);
          default: d = fd(4, 2);
        endcase
      end
      CMD_109: begin
        case (idx)
          4'd0:    d = fd(0, 4);
          default: d = fd(4, 2);
        endcase
      end
      CMD_110: begin
        case (idx)
          4'd0:    d = fd(0, 1);
          4'd1:    d = fd(1, 2);
          4'd2:    d = fd(3, 2);
          default: d = fd(5, 2);
        endcase
      end
      default: d = fd(0, 1);
    endcase
    return d;
  endfunction

endpackage

/* hdl/msprfd_ram.sv */
// ----------------------------------------------------------------------------
// MSP response frame decoder RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msprfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/msp_response_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// MSP response frame decoder
// Hunts for '$','M','>' response headers, buffers the payload and decodes
// the fields of known commands into little-endian values.
// ----------------------------------------------------------------------------
// Sequence: for a field frame each field is read byte by byte from the buffer,
//   captured and then emitted; request/unsupported events go straight to emit.
// Throughput: one byte per cycle while receiving; after a completed frame
//   input stalls until every field has been read, captured and emitted.
// Reset: hunt state, length and command clear; the payload buffer is not
//   cleared, bytes past the received length read as zero.
module msp_response_frame_decoder_top #(
  parameter int BUF_BYTES = msprfd_pkg::BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] command_code, [11:8] field_index,
                                   // [43:12] field_value, [47:44] zero
  output logic [1:0]  out_tuser,   // [1:0] event_kind
  output logic        out_tlast    // last_of_frame
);

  import msprfd_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);

  localparam logic [1:0] ST_RX   = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]    st_r, st_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [3:0]    fidx_r, fidx_nxt;
  logic [1:0]    bidx_r, bidx_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          byte_ok_r, byte_ok_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_cmd_r, out_cmd_nxt;
  logic [3:0]    out_idx_r, out_idx_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_acc;
  logic          done;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    cap_byte;
  logic [31:0]   fld_val;
  logic          out_free;
  logic          last_fld;
  field_desc_t   lf;

  assign in_tready = (st_r == ST_RX);
  assign in_acc    = in_tvalid && in_tready;
  assign lf        = layout_field(cmd_r, fidx_r);
  assign done      = (pos_r >= AW'(4)) && (9'(pos_r) == 9'(len_r) + 9'd4);
  assign out_free  = !out_valid_r || out_tready;
  assign last_fld  = (kind_r != EV_FIELD) || (fidx_r + 4'd1 == cnt_r);

  assign ram_we    = in_acc && (pos_r >= AW'(5));
  assign ram_waddr = pos_r - AW'(5);
  assign ram_re    = (st_r == ST_RD);
  assign ram_raddr = AW'(lf.off) + AW'(bidx_r);
  assign cap_byte  = byte_ok_r ? ram_rdata : 8'd0;
  assign fld_val   = (lf.size == 3'd2) ? {{16{acc_r[15]}}, acc_r[15:0]} : acc_r;

  msprfd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    cmd_nxt       = cmd_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    fidx_nxt      = fidx_r;
    bidx_nxt      = bidx_r;
    acc_nxt       = acc_r;
    byte_ok_nxt   = byte_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_cmd_nxt   = out_cmd_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    case (st_r)
      ST_RX: begin
        if (in_acc) begin
          if (pos_r == AW'(0)) begin
            if (in_tdata == HDR_START) pos_nxt = AW'(1);
          end else if (pos_r == AW'(1)) begin
            pos_nxt = (in_tdata == HDR_M) ? AW'(2) : AW'(0);
          end else if (pos_r == AW'(2)) begin
            pos_nxt = (in_tdata == HDR_DIR) ? AW'(3) : AW'(0);
          end else if (pos_r == AW'(3)) begin
            len_nxt = in_tdata;
            pos_nxt = ((9'(in_tdata) + 9'd5) > 9'(BUF_BYTES)) ? AW'(0) : AW'(4);
          end else begin
            if (pos_r == AW'(4)) cmd_nxt = in_tdata;
            if (done) begin
              pos_nxt  = AW'(0);
              fidx_nxt = 4'd0;
              bidx_nxt = 2'd0;
              acc_nxt  = 32'd0;
              cnt_nxt  = layout_count(cmd_r);
              if (len_r == 8'd0) begin
                kind_nxt = EV_REQUEST;
                st_nxt   = ST_EMIT;
              end else if (layout_count(cmd_r) == 4'd0) begin
                kind_nxt = EV_UNSUP;
                st_nxt   = ST_EMIT;
              end else begin
                kind_nxt = EV_FIELD;
                st_nxt   = ST_RD;
              end
            end else begin
              pos_nxt = pos_r + AW'(1);
            end
          end
        end
      end
      ST_RD: begin
        byte_ok_nxt = (9'(lf.off) + 9'(bidx_r)) < 9'(len_r);
        st_nxt      = ST_CAP;
      end
      ST_CAP: begin
        acc_nxt = acc_r | (32'(cap_byte) << {bidx_r, 3'b000});
        if (3'(bidx_r) + 3'd1 == lf.size) begin
          st_nxt = ST_EMIT;
        end else begin
          bidx_nxt = bidx_r + 2'd1;
          st_nxt   = ST_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_cmd_nxt   = cmd_r;
          out_idx_nxt   = (kind_r == EV_FIELD) ? fidx_r : 4'd0;
          out_val_nxt   = (kind_r == EV_FIELD) ? fld_val : 32'd0;
          out_last_nxt  = last_fld;
          if (last_fld) begin
            st_nxt = ST_RX;
          end else begin
            fidx_nxt = fidx_r + 4'd1;
            bidx_nxt = 2'd0;
            acc_nxt  = 32'd0;
            st_nxt   = ST_RD;
          end
        end
      end
      default: st_nxt = ST_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RX;
      pos_r       <= '0;
      len_r       <= '0;
      cmd_r       <= '0;
      kind_r      <= EV_FIELD;
      cnt_r       <= '0;
      fidx_r      <= '0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      cmd_r       <= cmd_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      fidx_r      <= fidx_nxt;
      bidx_r      <= bidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    byte_ok_r  <= byte_ok_nxt;
    out_kind_r <= out_kind_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_val_r, out_idx_r, out_cmd_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r >= AW'(5)) |-> (9'(pos_r) <= 9'(len_r) + 9'd4))
    else $error("byte position past end of frame");

  a_done_leaves_rx: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done && pos_r >= AW'(4)) |=> (st_r != ST_RX))
    else $error("completed frame did not start emission");

  a_field_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && kind_r == EV_FIELD) |-> (fidx_r < cnt_r))
    else $error("field index beyond layout");

  a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD || st_r == ST_CAP) |-> !ram_we)
    else $error("buffer written during field fetch");

endmodule

/* test/msp_response_frame_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP response frame decoder testbench
// Streams serial bytes into the decoder: a short directed sequence for the
// header, length and command corner cases, then randomized frames mixed with
// noise and broken headers. Both stream sides idle at random. A scoreboard
// tracks the frame state, predicts every field and event, and compares each
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module msp_response_frame_decoder_top_tb;
  import msprfd_pkg::*;

  localparam int BUF_BYTES   = BUF_BYTES_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int FRAME_ITEMS = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } frame_result_t;

  class frame_decode_scoreboard;
    int            frame_pos;
    logic [7:0]    frame_len;
    logic [7:0]    frame_cmd;
    logic [7:0]    payload[BUF_BYTES];
    frame_result_t decoded_q[$];
    int            errors;

    function new();
      frame_pos = 0;
      frame_len = '0;
      frame_cmd = '0;
      errors    = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function int field_layout(logic [7:0] code, output int offs[9], output int sizes[9]);
      offs  = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      sizes = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      case (code)
        CMD_100: begin
          offs  = '{0, 1, 2, 3, 0, 0, 0, 0, 0};
          sizes = '{1, 1, 1, 4, 0, 0, 0, 0, 0};
          return 4;
        end
        CMD_101: begin
          offs  = '{0, 2, 4, 6, 10, 0, 0, 0, 0};
          sizes = '{2, 2, 2, 4, 1, 0, 0, 0, 0};
          return 5;
        end
        CMD_102: begin
          offs  = '{0, 2, 4, 6, 8, 10, 12, 14, 16};
          sizes = '{2, 2, 2, 2, 2, 2, 2, 2, 2};
          return 9;
        end
        CMD_106: begin
          offs  = '{0, 1, 2, 6, 10, 12, 0, 0, 0};
          sizes = '{1, 1, 4, 4, 2, 2, 0, 0, 0};
          return 6;
        end
        CMD_108: begin
          offs  = '{0, 2, 4, 0, 0, 0, 0, 0, 0};
          sizes = '{2, 2, 2, 0, 0, 0, 0, 0, 0};
          return 3;
        end
        CMD_109: begin
          offs  = '{0, 4, 0, 0, 0, 0, 0, 0, 0};
          sizes = '{4, 2, 0, 0, 0, 0, 0, 0, 0};
          return 2;
        end
        CMD_110: begin
          offs  = '{0, 1, 3, 5, 0, 0, 0, 0, 0};
          sizes = '{1, 2, 2, 2, 0, 0, 0, 0, 0};
          return 4;
        end
        default: return 0;
      endcase
    endfunction

    function void emit_frame();
      int            offs[9];
      int            sizes[9];
      int            count;
      logic [31:0]   v;
      frame_result_t r;
      r.code  = frame_cmd;
      r.index = '0;
      r.value = '0;
      r.last  = 1'b1;
      if (frame_len == 8'd0) begin
        r.kind = EV_REQUEST;
        decoded_q.push_back(r);
        return;
      end
      count = field_layout(frame_cmd, offs, sizes);
      if (count == 0) begin
        r.kind = EV_UNSUP;
        decoded_q.push_back(r);
        return;
      end
      for (int f = 0; f < count; f++) begin
        v = '0;
        for (int i = 0; i < sizes[f]; i++) begin
          if (offs[f] + i < BUF_BYTES) v[8*i +: 8] = payload[offs[f] + i];
        end
        if (sizes[f] == 2 && v[15]) v[31:16] = 16'hFFFF;
        r.kind  = EV_FIELD;
        r.index = 4'(f);
        r.value = v;
        r.last  = (f == count - 1);
        decoded_q.push_back(r);
      end
    endfunction

    function void decode_byte(logic [7:0] b);
      if (frame_pos == 0) begin
        if (b == HDR_START) begin
          foreach (payload[i]) payload[i] = '0;
          frame_pos = 1;
        end
      end else if (frame_pos == 1) begin
        frame_pos = (b == HDR_M) ? 2 : 0;
      end else if (frame_pos == 2) begin
        frame_pos = (b == HDR_DIR) ? 3 : 0;
      end else if (frame_pos == 3) begin
        frame_len = b;
        frame_pos = (int'(b) + 5 > BUF_BYTES) ? 0 : 4;
      end else begin
        if (frame_pos == 4) frame_cmd = b;
        else if (frame_pos - 5 < BUF_BYTES) payload[frame_pos - 5] = b;
        if (frame_pos >= 4 + int'(frame_len)) begin
          frame_pos = 0;
          emit_frame();
        end else begin
          frame_pos++;
        end
      end
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s expected %0h actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(logic [1:0] kind, logic [47:0] data, logic last);
      frame_result_t w;
      if (decoded_q.size() == 0) begin
        $error("unexpected result kind %0d code %0d", kind, data[7:0]);
        errors++;
        return;
      end
      w = decoded_q.pop_front();
      check_field("event_kind", w.kind, kind);
      check_field("command_code", w.code, data[7:0]);
      check_field("field_index", w.index, data[11:8]);
      check_field("field_value", w.value, data[43:12]);
      check_field("tdata_pad", 0, data[47:44]);
      check_field("last_of_frame", w.last, last);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  frame_decode_scoreboard sb;
  bit   in_steady;
  bit   out_steady;
  int   frame_bytes;
  int   idle_cycles;

  const logic [7:0] known_cmds[7] = '{CMD_100, CMD_101, CMD_102, CMD_106,
                                      CMD_108, CMD_109, CMD_110};
  const int         layout_bytes[7] = '{7, 11, 18, 14, 6, 6, 7};

  always #10 clk = ~clk;

  msp_response_frame_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    frame_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int len);
    send_byte(HDR_START);
    send_byte(HDR_M);
    send_byte(HDR_DIR);
    send_byte(8'(len));
    send_byte(cmd);
    for (int i = 0; i < len; i++) send_byte(payload_byte());
    send_byte(8'($urandom));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.decode_byte(in_tdata);
      if (out_tvalid && out_tready) sb.compare_result(out_tuser, out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = pick_gap(out_steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 19) == 0) out_steady = !out_steady;
    end
  end

  initial begin
    int r;
    int k;
    int len;
    sb          = new();
    frame_bytes = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length frame -> request event
    send_byte(HDR_START); send_byte(HDR_M); send_byte(HDR_DIR);
    send_byte(8'h00); send_byte(CMD_100);
    // repeated start byte drops back to hunting without restarting
    send_byte(HDR_START); send_byte(HDR_START); send_byte(HDR_M); send_byte(HDR_DIR);
    // overlong length discards the frame
    send_byte(HDR_START); send_byte(HDR_M); send_byte(HDR_DIR); send_byte(8'd60);
    // unknown command -> unsupported event
    send_byte(HDR_START); send_byte(HDR_M); send_byte(HDR_DIR);
    send_byte(8'h01); send_byte(8'hFF); send_byte(8'h80);
    // short payload: missing bytes read as zero
    send_byte(HDR_START); send_byte(HDR_M); send_byte(HDR_DIR);
    send_byte(8'h02); send_byte(CMD_109); send_byte(8'hFF); send_byte(8'hFF);
    drain_results();

    while (frame_bytes < FRAME_ITEMS) begin
      if ($urandom_range(0, 4) == 0) in_steady = !in_steady;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        k = $urandom_range(0, 6);
        case ($urandom_range(0, 19))
          0, 1, 2:    len = $urandom_range(1, layout_bytes[k] - 1);
          3, 4:       len = $urandom_range(layout_bytes[k], layout_bytes[k] + 8);
          5:          len = ($urandom_range(0, 2) == 0) ? BUF_BYTES - 5 : layout_bytes[k];
          default:    len = layout_bytes[k];
        endcase
        send_frame(known_cmds[k], len);
      end else if (r < 77) begin
        send_frame(8'($urandom), 0);
      end else if (r < 85) begin
        send_frame(8'($urandom), $urandom_range(1, 10));
      end else if (r < 90) begin
        send_byte(HDR_START); send_byte(HDR_M); send_byte(HDR_DIR);
        send_byte(8'($urandom_range(BUF_BYTES - 4, 255)));
      end else if (r < 95) begin
        send_byte(HDR_START);
        if ($urandom_range(0, 1) == 1) send_byte(HDR_M);
        send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/msprfd_pkg.sv
hdl/msprfd_ram.sv
hdl/msp_response_frame_decoder_top.sv
test/msp_response_frame_decoder_top_tb.sv
